// ----- hdl/ipfx_pkg.sv -----
package ipfx_pkg;

	// Frame layout, counted in bytes from the first byte of the Ethernet header.
	localparam logic [15:0] POS_ETYPE_HI  = 16'd12;
	localparam logic [15:0] POS_ETYPE_LO  = 16'd13;
	localparam logic [15:0] POS_VER_IHL   = 16'd14;
	localparam logic [15:0] POS_TLEN_HI   = 16'd16;
	localparam logic [15:0] POS_TLEN_LO   = 16'd17;
	localparam logic [15:0] POS_PROTO     = 16'd23;
	localparam logic [15:0] POS_SIP_FIRST = 16'd26;
	localparam logic [15:0] POS_SIP_LAST  = 16'd29;
	localparam logic [15:0] POS_DIP_FIRST = 16'd30;
	localparam logic [15:0] POS_DIP_LAST  = 16'd33;

	// The byte position stops counting at this value.
	localparam logic [15:0] POS_MAX = 16'hFFFF;

	localparam logic [6:0]  ETH_HDR_BYTES  = 7'd14;
	localparam logic [6:0]  HDR_WORD_BYTES = 7'd4;
	localparam logic [16:0] MIN_FRAME_BYTES = 17'd34;
	localparam logic [16:0] TCP_HDR_BYTES   = 17'd20;
	localparam logic [16:0] UDP_HDR_BYTES   = 17'd8;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;

	// One frame byte handed to the parser.
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       last;
	} ipfx_step_t;

	// One flow event.
	typedef struct packed {
		logic [31:0] source_ip;
		logic [31:0] dest_ip;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic [15:0] ip_total_length;
		logic [7:0]  ip_protocol;
	} ipfx_event_t;

endpackage

// ----- hdl/ipfx_intf.sv -----
// Byte stream of an Ethernet frame.
interface ipfx_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// Stream of flow events.
interface ipfx_event_if;
	logic        valid;
	logic        ready;
	logic [31:0] source_ip;
	logic [31:0] dest_ip;
	logic [15:0] source_port;
	logic [15:0] dest_port;
	logic [15:0] ip_total_length;
	logic [7:0]  ip_protocol;

	modport source (output valid, output source_ip, output dest_ip, output source_port,
		output dest_port, output ip_total_length, output ip_protocol, input ready);
	modport sink (input valid, input source_ip, input dest_ip, input source_port,
		input dest_port, input ip_total_length, input ip_protocol, output ready);
endinterface

// ----- hdl/ipfx_parser.sv -----
module ipfx_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ipfx_pkg::ipfx_step_t  step,
	output logic                  evt_valid,
	output ipfx_pkg::ipfx_event_t evt
);

	// Per-frame field capture registers.
	logic [15:0] pos_q;
	logic [15:0] etype_q;
	logic [3:0]  ihl_q;
	logic [15:0] tlen_q;
	logic [7:0]  proto_q;
	logic [31:0] sip_q;
	logic [31:0] dip_q;
	logic [15:0] sport_q;
	logic [15:0] dport_q;

	logic        counted;
	logic [15:0] pos_n;
	logic [15:0] etype_n;
	logic [3:0]  ihl_n;
	logic [15:0] tlen_n;
	logic [7:0]  proto_n;
	logic [31:0] sip_n;
	logic [31:0] dip_n;
	logic [15:0] sport_n;
	logic [15:0] dport_n;
	logic [6:0]  base;
	logic [15:0] base16;
	logic [16:0] frame_len;
	logic        qualify;
	logic        ports_ok;

	// Field capture for the current byte. The IHL nibble taken from this very byte
	// already sets the transport header offset.
	always_comb begin
		counted = pos_q != ipfx_pkg::POS_MAX;
		etype_n = etype_q;
		ihl_n   = ihl_q;
		tlen_n  = tlen_q;
		proto_n = proto_q;
		sip_n   = sip_q;
		dip_n   = dip_q;
		sport_n = sport_q;
		dport_n = dport_q;
		if (counted) begin
			if (pos_q == ipfx_pkg::POS_ETYPE_HI || pos_q == ipfx_pkg::POS_ETYPE_LO) begin
				etype_n = {etype_q[7:0], step.data};
			end
			if (pos_q == ipfx_pkg::POS_VER_IHL) begin
				ihl_n = step.data[3:0];
			end
			if (pos_q == ipfx_pkg::POS_TLEN_HI || pos_q == ipfx_pkg::POS_TLEN_LO) begin
				tlen_n = {tlen_q[7:0], step.data};
			end
			if (pos_q == ipfx_pkg::POS_PROTO) begin
				proto_n = step.data;
			end
			if (pos_q >= ipfx_pkg::POS_SIP_FIRST && pos_q <= ipfx_pkg::POS_SIP_LAST) begin
				sip_n = {sip_q[23:0], step.data};
			end
			if (pos_q >= ipfx_pkg::POS_DIP_FIRST && pos_q <= ipfx_pkg::POS_DIP_LAST) begin
				dip_n = {dip_q[23:0], step.data};
			end
		end

		base   = ipfx_pkg::ETH_HDR_BYTES + 7'({3'd0, ihl_n} * ipfx_pkg::HDR_WORD_BYTES);
		base16 = {9'd0, base};
		if (counted) begin
			if (pos_q == base16 || pos_q == base16 + 16'd1) begin
				sport_n = {sport_q[7:0], step.data};
			end
			if (pos_q == base16 + 16'd2 || pos_q == base16 + 16'd3) begin
				dport_n = {dport_q[7:0], step.data};
			end
		end

		pos_n     = counted ? pos_q + 16'd1 : pos_q;
		frame_len = {1'b0, pos_q} + 17'd1;
	end

	// Event decision on the last byte of a frame.
	always_comb begin
		qualify  = frame_len >= ipfx_pkg::MIN_FRAME_BYTES && etype_n == ipfx_pkg::ETHERTYPE_IPV4;
		ports_ok = (proto_n == ipfx_pkg::PROTO_TCP &&
				frame_len >= {10'd0, base} + ipfx_pkg::TCP_HDR_BYTES) ||
			(proto_n == ipfx_pkg::PROTO_UDP &&
				frame_len >= {10'd0, base} + ipfx_pkg::UDP_HDR_BYTES);
		evt_valid           = step.valid && step.last && qualify;
		evt.source_ip       = sip_n;
		evt.dest_ip         = dip_n;
		evt.source_port     = ports_ok ? sport_n : 16'd0;
		evt.dest_port       = ports_ok ? dport_n : 16'd0;
		evt.ip_total_length = tlen_n;
		evt.ip_protocol     = proto_n;
	end

	// State update; the last byte of a frame clears everything for the next one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			etype_q <= '0;
			ihl_q   <= '0;
			tlen_q  <= '0;
			proto_q <= '0;
			sip_q   <= '0;
			dip_q   <= '0;
			sport_q <= '0;
			dport_q <= '0;
		end else if (step.valid) begin
			if (step.last) begin
				pos_q   <= '0;
				etype_q <= '0;
				ihl_q   <= '0;
				tlen_q  <= '0;
				proto_q <= '0;
				sip_q   <= '0;
				dip_q   <= '0;
				sport_q <= '0;
				dport_q <= '0;
			end else begin
				pos_q   <= pos_n;
				etype_q <= etype_n;
				ihl_q   <= ihl_n;
				tlen_q  <= tlen_n;
				proto_q <= proto_n;
				sip_q   <= sip_n;
				dip_q   <= dip_n;
				sport_q <= sport_n;
				dport_q <= dport_n;
			end
		end
	end

`ifndef NO_ASSERTIONS
	// A frame always starts again at position zero after its last byte.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		step.valid && step.last |=> pos_q == 16'd0)
		else $error("position not cleared after last byte");

	// An event needs at least the full IPv4 address block.
	a_min_len: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid |-> pos_q >= ipfx_pkg::POS_DIP_LAST)
		else $error("event from a frame that is too short");

	// The position counter holds once it has saturated.
	a_saturate: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q == ipfx_pkg::POS_MAX && step.valid && !step.last |=> pos_q == ipfx_pkg::POS_MAX)
		else $error("position counter wrapped");
`endif

endmodule

// ----- hdl/ipv4_flow_header_extractor.sv -----
// Parses Ethernet frames arriving one byte per transfer and emits one flow event
// (IPv4 addresses, total length, protocol and, for complete TCP or UDP headers,
// the ports) on the last byte of every IPv4 frame of at least 34 bytes. Other
// frames produce no event. A byte can be taken in every cycle: each byte passes
// an input register and the single field-capture stage, and the event for a
// frame is offered from an output register. The block stalls only while a
// finished event is held in the output register by a stalled receiver and
// the next byte already waits in the input register.
module ipv4_flow_header_extractor (
	input  logic                clk,
	input  logic                arst_n,
	ipfx_byte_if.sink           frame,
	ipfx_event_if.source        flow
);

	logic                  valid_s1;
	logic [7:0]            data_s1;
	logic                  last_s1;
	logic                  advance;
	logic                  evt_valid;
	ipfx_pkg::ipfx_event_t evt;
	ipfx_pkg::ipfx_step_t  step;
	logic                  out_valid_q;
	ipfx_pkg::ipfx_event_t out_q;

	// The capture stage moves whenever the output register is free or being emptied.
	assign advance     = !out_valid_q || flow.ready;
	assign frame.ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.valid && frame.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.valid && frame.ready) begin
			data_s1 <= frame.data_byte;
			last_s1 <= frame.last_byte;
		end
	end

	assign step.valid = valid_s1 && advance;
	assign step.data  = data_s1;
	assign step.last  = last_s1;

	ipfx_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.evt_valid (evt_valid),
		.evt       (evt)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && evt_valid) begin
			out_q <= evt;
		end
	end

	assign flow.valid           = out_valid_q;
	assign flow.source_ip       = out_q.source_ip;
	assign flow.dest_ip         = out_q.dest_ip;
	assign flow.source_port     = out_q.source_port;
	assign flow.dest_port       = out_q.dest_port;
	assign flow.ip_total_length = out_q.ip_total_length;
	assign flow.ip_protocol     = out_q.ip_protocol;

`ifndef NO_ASSERTIONS
	// A new event only ever follows a last byte leaving the input register.
	a_evt_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && last_s1))
		else $error("event without a preceding last byte");

	// A held byte must block the input side.
	a_hold_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !flow.ready |=> valid_s1 && $stable(data_s1))
		else $error("held byte lost while the output stalled");

	// A stalled event is never overwritten.
	a_evt_kept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !flow.ready |=> out_valid_q && $stable(out_q))
		else $error("stalled event overwritten");
`endif

endmodule

// ----- bench/ipv4_flow_header_extractor_test.sv -----
module ipv4_flow_header_extractor_test;

	// How a directed frame is checked: by the flow predictor, or against values typed in.
	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_NO_EVENT,
		ROW_WITH_PORTS,
		ROW_PORTS_ZERO
	} row_check_t;

	// One frame to send, described by its header fields.
	typedef struct {
		int unsigned len;
		logic [15:0] etype;
		logic [7:0]  ver_ihl;
		logic [15:0] tlen;
		logic [7:0]  proto;
		logic [31:0] sip;
		logic [31:0] dip;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [7:0]  fill;
		row_check_t  check;
	} frame_row_t;

	localparam int DIRECTED_ROWS = 18;
	localparam int RANDOM_BYTES  = 1600;
	localparam int RANDOM_EVENTS = 60;

	logic clk;
	logic arst_n;

	ipfx_byte_if  frame_bus ();
	ipfx_event_if flow_bus ();

	ipv4_flow_header_extractor u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame_bus),
		.flow   (flow_bus)
	);

	// Directed frames: well-formed TCP and UDP, extremes, truncation, short and foreign frames,
	// small header lengths and a frame long enough to saturate the byte position.
	frame_row_t directed_frames [DIRECTED_ROWS] = '{
		'{54, 16'h0800, 8'h45, 16'd40, ipfx_pkg::PROTO_TCP, 32'hC0A8_0001, 32'h0A00_0002,
			16'h1234, 16'h0050, 8'h00, ROW_WITH_PORTS},
		'{42, 16'h0800, 8'h45, 16'd28, ipfx_pkg::PROTO_UDP, 32'h0A0A_0A0A, 32'hC000_0201,
			16'h0035, 16'hD431, 8'h5A, ROW_WITH_PORTS},
		'{41, 16'h0800, 8'h45, 16'd28, ipfx_pkg::PROTO_UDP, 32'h0102_0304, 32'h0506_0708,
			16'h1111, 16'h2222, 8'hA5, ROW_PORTS_ZERO},
		'{53, 16'h0800, 8'h45, 16'd40, ipfx_pkg::PROTO_TCP, 32'h1122_3344, 32'h5566_7788,
			16'h3333, 16'h4444, 8'h3C, ROW_PORTS_ZERO},
		'{94, 16'h0800, 8'hFF, 16'hFFFF, ipfx_pkg::PROTO_TCP, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			16'hFFFF, 16'hFFFF, 8'hFF, ROW_WITH_PORTS},
		'{42, 16'h0800, 8'h45, 16'h0000, ipfx_pkg::PROTO_UDP, 32'h0000_0000, 32'h0000_0000,
			16'h0000, 16'h0000, 8'h00, ROW_WITH_PORTS},
		'{60, 16'h0800, 8'h45, 16'd46, 8'hFF, 32'hAC10_0001, 32'hAC10_00FE,
			16'h5555, 16'h6666, 8'h81, ROW_PORTS_ZERO},
		'{60, 16'h0800, 8'h45, 16'd46, 8'h00, 32'h7F00_0001, 32'h7F00_0002,
			16'h7777, 16'h8888, 8'h18, ROW_PORTS_ZERO},
		'{33, 16'h0800, 8'h45, 16'd19, ipfx_pkg::PROTO_TCP, 32'h0101_0101, 32'h0202_0202,
			16'h9999, 16'hAAAA, 8'h42, ROW_NO_EVENT},
		'{1, 16'h0800, 8'h45, 16'd20, ipfx_pkg::PROTO_TCP, 32'h0303_0303, 32'h0404_0404,
			16'hBBBB, 16'hCCCC, 8'hE7, ROW_NO_EVENT},
		'{60, 16'h86DD, 8'h45, 16'd46, ipfx_pkg::PROTO_TCP, 32'h0505_0505, 32'h0606_0606,
			16'hDDDD, 16'hEEEE, 8'h11, ROW_NO_EVENT},
		'{60, 16'h0801, 8'h45, 16'd46, ipfx_pkg::PROTO_UDP, 32'h0707_0707, 32'h0808_0808,
			16'h0102, 16'h0304, 8'h99, ROW_NO_EVENT},
		'{34, 16'h0800, 8'h45, 16'd20, ipfx_pkg::PROTO_TCP, 32'h0909_0909, 32'h0A0A_0A0B,
			16'h0506, 16'h0708, 8'h6E, ROW_PORTS_ZERO},
		'{34, 16'h0800, 8'h40, 16'd20, ipfx_pkg::PROTO_UDP, 32'h1234_5678, 32'h9ABC_DEF0,
			16'h0A0B, 16'h0C0D, 8'h27, ROW_PREDICT},
		'{38, 16'h0800, 8'h41, 16'd24, ipfx_pkg::PROTO_TCP, 32'h2345_6789, 32'hABCD_EF01,
			16'h0E0F, 16'h1011, 8'hD2, ROW_PREDICT},
		'{50, 16'h0800, 8'h44, 16'd36, ipfx_pkg::PROTO_TCP, 32'h3456_789A, 32'hBCDE_F012,
			16'h1213, 16'h1415, 8'h4B, ROW_PREDICT},
		'{65540, 16'h0800, 8'h45, 16'hFFEA, ipfx_pkg::PROTO_TCP, 32'hDEAD_BEEF, 32'hCAFE_F00D,
			16'hABCD, 16'hEF01, 8'h5C, ROW_WITH_PORTS},
		'{42, 16'h0800, 8'h45, 16'd28, ipfx_pkg::PROTO_UDP, 32'h8000_0001, 32'h0000_0080,
			16'h8001, 16'h0180, 8'h00, ROW_PREDICT}
	};

	// Flow predictor state, cleared after every last byte.
	logic [15:0] hdr_pos;
	logic [15:0] hdr_etype;
	logic [3:0]  hdr_ihl;
	logic [15:0] hdr_tlen;
	logic [7:0]  hdr_proto;
	logic [31:0] hdr_sip;
	logic [31:0] hdr_dip;
	logic [15:0] hdr_sport;
	logic [15:0] hdr_dport;

	ipfx_pkg::ipfx_event_t flow_events_due [$];
	int unsigned events_predicted;
	int unsigned bytes_sent;
	int unsigned flow_errors;
	int unsigned burst_left;
	bit          gaps_on;

	// Clock with a period of 12.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic void clear_flow_state();
		hdr_pos   = '0;
		hdr_etype = '0;
		hdr_ihl   = '0;
		hdr_tlen  = '0;
		hdr_proto = '0;
		hdr_sip   = '0;
		hdr_dip   = '0;
		hdr_sport = '0;
		hdr_dport = '0;
	endfunction

	// Advances the predictor by one accepted byte and gives the flow event it completes, if any.
	function automatic void parse_frame_byte(input logic [7:0] b, input logic lst,
		output bit has, output ipfx_pkg::ipfx_event_t ev);
		logic [15:0] pos;
		logic        counted;
		logic [16:0] base;
		logic [16:0] flen;
		pos = hdr_pos;
		counted = hdr_pos != ipfx_pkg::POS_MAX;
		has = 1'b0;
		ev = '0;
		if (counted) begin
			if (pos == ipfx_pkg::POS_ETYPE_HI || pos == ipfx_pkg::POS_ETYPE_LO)
				hdr_etype = {hdr_etype[7:0], b};
			if (pos == ipfx_pkg::POS_VER_IHL)
				hdr_ihl = b[3:0];
			if (pos == ipfx_pkg::POS_TLEN_HI || pos == ipfx_pkg::POS_TLEN_LO)
				hdr_tlen = {hdr_tlen[7:0], b};
			if (pos == ipfx_pkg::POS_PROTO)
				hdr_proto = b;
			if (pos >= ipfx_pkg::POS_SIP_FIRST && pos <= ipfx_pkg::POS_SIP_LAST)
				hdr_sip = {hdr_sip[23:0], b};
			if (pos >= ipfx_pkg::POS_DIP_FIRST && pos <= ipfx_pkg::POS_DIP_LAST)
				hdr_dip = {hdr_dip[23:0], b};
		end
		// The transport header starts after the IP header as the IHL nibble stands now.
		base = 17'(ipfx_pkg::ETH_HDR_BYTES) + 17'(hdr_ihl) * 17'(ipfx_pkg::HDR_WORD_BYTES);
		if (counted) begin
			if ({1'b0, pos} == base || {1'b0, pos} == base + 17'd1)
				hdr_sport = {hdr_sport[7:0], b};
			if ({1'b0, pos} == base + 17'd2 || {1'b0, pos} == base + 17'd3)
				hdr_dport = {hdr_dport[7:0], b};
		end
		flen = {1'b0, pos} + 17'd1;
		if (counted)
			hdr_pos = pos + 16'd1;
		if (lst) begin
			if (flen >= ipfx_pkg::MIN_FRAME_BYTES && hdr_etype == ipfx_pkg::ETHERTYPE_IPV4) begin
				has = 1'b1;
				ev.source_ip = hdr_sip;
				ev.dest_ip = hdr_dip;
				ev.ip_total_length = hdr_tlen;
				ev.ip_protocol = hdr_proto;
				if ((hdr_proto == ipfx_pkg::PROTO_TCP &&
						flen >= base + ipfx_pkg::TCP_HDR_BYTES) ||
					(hdr_proto == ipfx_pkg::PROTO_UDP &&
						flen >= base + ipfx_pkg::UDP_HDR_BYTES)) begin
					ev.source_port = hdr_sport;
					ev.dest_port = hdr_dport;
				end
			end
			clear_flow_state();
		end
	endfunction

	// Presents one byte, possibly idling first when a burst has run out, and waits for its transfer.
	task automatic send_byte(input logic [7:0] b, input logic lst);
		int unsigned idle;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			idle = gaps_on ? $urandom_range(0, 6) : 0;
			if (idle != 0) begin
				frame_bus.valid <= 1'b0;
				repeat (idle) @(posedge clk);
			end
		end
		burst_left--;
		frame_bus.valid <= 1'b1;
		frame_bus.data_byte <= b;
		frame_bus.last_byte <= lst;
		do
			@(posedge clk);
		while (!frame_bus.ready);
	endtask

	// Builds the bytes of a frame from its header fields and sends them, recording each event due.
	task automatic send_frame(input frame_row_t row, input bit rand_fill);
		logic [7:0]  frame_q [$];
		logic [7:0]  v;
		logic [31:0] ports;
		int unsigned base;
		bit          has;
		ipfx_pkg::ipfx_event_t ev;
		logic        lst;
		base = 14 + 4 * int'(row.ver_ihl[3:0]);
		ports = {row.sport, row.dport};
		for (int unsigned i = 0; i < row.len; i++) begin
			v = rand_fill ? 8'($urandom) : row.fill;
			case (i)
				12: v = row.etype[15:8];
				13: v = row.etype[7:0];
				14: v = row.ver_ihl;
				16: v = row.tlen[15:8];
				17: v = row.tlen[7:0];
				23: v = row.proto;
				26, 27, 28, 29: v = row.sip[31 - 8 * (i - 26) -: 8];
				30, 31, 32, 33: v = row.dip[31 - 8 * (i - 30) -: 8];
				default: begin
					if (i >= base && i < base + 4)
						v = ports[31 - 8 * (i - base) -: 8];
				end
			endcase
			frame_q.push_back(v);
		end
		for (int unsigned i = 0; i < frame_q.size(); i++) begin
			lst = (i == frame_q.size() - 1);
			send_byte(frame_q[i], lst);
			parse_frame_byte(frame_q[i], lst, has, ev);
			if (lst && row.check != ROW_PREDICT) begin
				has = row.check != ROW_NO_EVENT;
				ev.source_ip = row.sip;
				ev.dest_ip = row.dip;
				ev.source_port = (row.check == ROW_WITH_PORTS) ? row.sport : 16'h0000;
				ev.dest_port = (row.check == ROW_WITH_PORTS) ? row.dport : 16'h0000;
				ev.ip_total_length = row.tlen;
				ev.ip_protocol = row.proto;
			end
			if (has) begin
				flow_events_due.push_back(ev);
				events_predicted++;
			end
		end
		bytes_sent += frame_q.size();
	endtask

	// Stops the sender until every event due has been taken.
	task automatic hold_sender_until_drained();
		frame_bus.valid <= 1'b0;
		burst_left = 0;
		do
			@(posedge clk);
		while (flow_events_due.size() != 0);
	endtask

	// Main stimulus: reset, directed frames, then random frames.
	initial begin
		frame_row_t  row;
		int          want_len;
		int unsigned hdr_need;
		int unsigned kind;
		int unsigned frame_count;
		int unsigned random_start_bytes;
		int unsigned random_start_events;
		arst_n <= 1'b0;
		frame_bus.valid <= 1'b0;
		frame_bus.data_byte <= '0;
		frame_bus.last_byte <= 1'b0;
		clear_flow_state();
		events_predicted = 0;
		bytes_sent = 0;
		flow_errors = 0;
		burst_left = 0;
		gaps_on = 1'b1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++)
			send_frame(directed_frames[i], 1'b0);
		hold_sender_until_drained();

		// Random part: mostly IPv4 frames with random content, the rest noise and near misses.
		random_start_bytes = bytes_sent;
		random_start_events = events_predicted;
		frame_count = 0;
		while (bytes_sent - random_start_bytes < RANDOM_BYTES ||
			events_predicted - random_start_events < RANDOM_EVENTS) begin
			if (frame_count % 8 == 0)
				gaps_on = $urandom_range(0, 3) != 0;
			kind = $urandom_range(0, 9);
			row.etype = ipfx_pkg::ETHERTYPE_IPV4;
			row.ver_ihl = ($urandom_range(0, 4) == 0) ? 8'($urandom) :
				{4'h4, 4'($urandom_range(0, 4) == 0 ? $urandom_range(0, 15) : 5)};
			case ($urandom_range(0, 4))
				0, 1: row.proto = ipfx_pkg::PROTO_TCP;
				2, 3: row.proto = ipfx_pkg::PROTO_UDP;
				default: row.proto = 8'($urandom);
			endcase
			row.tlen = 16'($urandom);
			row.sip = $urandom;
			row.dip = $urandom;
			row.sport = 16'($urandom);
			row.dport = 16'($urandom);
			row.fill = 8'h00;
			row.check = ROW_PREDICT;
			hdr_need = (row.proto == ipfx_pkg::PROTO_TCP) ? 20 : 8;
			want_len = 14 + 4 * int'(row.ver_ihl[3:0]) + int'(hdr_need) +
				$urandom_range(0, 14) - 4;
			if ($urandom_range(0, 9) == 0)
				want_len += $urandom_range(0, 200);
			if (want_len < 34 && $urandom_range(0, 3) != 0)
				want_len = 34 + $urandom_range(0, 6);
			case (kind)
				0: begin
					row.etype = 16'($urandom);
					want_len = $urandom_range(1, 80);
				end
				1: want_len = $urandom_range(1, 33);
				2: row.etype = ipfx_pkg::ETHERTYPE_IPV4 ^ (16'd1 << $urandom_range(0, 15));
				default: ;
			endcase
			row.len = (want_len < 1) ? 1 : want_len;
			send_frame(row, 1'b1);
			frame_count++;
			if (frame_count == 20)
				hold_sender_until_drained();
		end
		frame_bus.valid <= 1'b0;

		// Let the last events out, bounded, then keep watching quietly for strays.
		for (int i = 0; i < 5000 && flow_events_due.size() != 0; i++)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (flow_events_due.size() != 0) begin
			$error("%0d flow events never arrived", flow_events_due.size());
			flow_errors += flow_events_due.size();
		end
		if (flow_errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Receiver: stalls on a rotating pattern and checks each event transfer against the oldest due.
	initial begin
		logic [15:0] ready_pattern;
		int unsigned rx_cycle;
		ipfx_pkg::ipfx_event_t want;
		ready_pattern = 16'hFFFF;
		rx_cycle = 0;
		flow_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && flow_bus.valid && flow_bus.ready) begin
				if (flow_events_due.size() == 0) begin
					$error("flow event with none due: source_ip %h dest_ip %h",
						flow_bus.source_ip, flow_bus.dest_ip);
					flow_errors++;
				end else begin
					want = flow_events_due.pop_front();
					if (flow_bus.source_ip !== want.source_ip) begin
						$error("source_ip: expected %h, got %h", want.source_ip,
							flow_bus.source_ip);
						flow_errors++;
					end
					if (flow_bus.dest_ip !== want.dest_ip) begin
						$error("dest_ip: expected %h, got %h", want.dest_ip, flow_bus.dest_ip);
						flow_errors++;
					end
					if (flow_bus.source_port !== want.source_port) begin
						$error("source_port: expected %h, got %h", want.source_port,
							flow_bus.source_port);
						flow_errors++;
					end
					if (flow_bus.dest_port !== want.dest_port) begin
						$error("dest_port: expected %h, got %h", want.dest_port,
							flow_bus.dest_port);
						flow_errors++;
					end
					if (flow_bus.ip_total_length !== want.ip_total_length) begin
						$error("ip_total_length: expected %h, got %h", want.ip_total_length,
							flow_bus.ip_total_length);
						flow_errors++;
					end
					if (flow_bus.ip_protocol !== want.ip_protocol) begin
						$error("ip_protocol: expected %h, got %h", want.ip_protocol,
							flow_bus.ip_protocol);
						flow_errors++;
					end
				end
			end
			// The ready pattern is redrawn as rx_cycle advances; bit 0 is always set, so every pattern has a ready slot.
			if (rx_cycle % 256 == 0) begin
				case ($urandom_range(0, 3))
					0: ready_pattern = 16'hFFFF;
					1: ready_pattern = 16'($urandom) & 16'($urandom) | 16'h0001;
					default: ready_pattern = 16'($urandom) | 16'h0001;
				endcase
			end
			flow_bus.ready <= ready_pattern[rx_cycle % 16];
			rx_cycle++;
		end
	end

	// Overall limit on the run.
	initial begin
		#36000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
